// File: rtl/cva_pkg.sv
// Shared constants and angle helpers for the vectoring CORDIC arctangent core.
// No dependencies; every RTL file of the core imports this package.
`default_nettype none

package cva_pkg;

  localparam int unsigned LAST_STEP_DEFAULT       = 8;
  localparam int unsigned COORD_WIDTH_DEFAULT     = 16;
  localparam int unsigned ANGLE_FRAC_BITS_DEFAULT = 13;

  // The result and the angle accumulator are always 16 bits wide.
  localparam int unsigned ANGLE_WIDTH = 16;

  localparam int unsigned    ATAN_ENTRIES = 9;
  localparam longint unsigned AtanDen     = 64'd10000;
  localparam longint unsigned AtanHalf    = 64'd5000;
  localparam longint unsigned PiQ30       = 64'd3373259426;

  typedef logic [ANGLE_WIDTH-1:0] angle_t;

  // atan(2^-k) in units of 1e-4 rad.
  localparam longint unsigned ATAN_E4 [ATAN_ENTRIES] = '{
    64'd7854, 64'd4636, 64'd2450, 64'd1244, 64'd624,
    64'd312,  64'd156,  64'd78,   64'd39
  };

  // Table entry rounded to the nearest step of the angle grid, half up.
  function automatic angle_t atan_entry(input logic [3:0] k, input int unsigned frac);
    longint unsigned scaled;
    scaled = ATAN_E4[k] << frac;
    return ANGLE_WIDTH'((scaled + AtanHalf) / AtanDen);
  endfunction

  // Pi shifted right by extra (0 gives pi, 1 gives pi/2), rounded half up.
  function automatic angle_t pi_value(input int unsigned frac, input int unsigned extra);
    int unsigned s;
    s = (30 - frac) + extra;
    return ANGLE_WIDTH'((PiQ30 + (64'd1 << (s - 1))) >> s);
  endfunction

endpackage

`default_nettype wire

// File: rtl/cordic_vectoring_atan2_core.sv
// An accepted request passes the entry stage, the iteration stages and the output register.
// Throughput: one request per cycle while the output is not stalled; each iteration stage
// holds one CORDIC iteration (a shift-add on x and y but in the last, plus a table add on the angle).
// Reset clears every stage valid bit asynchronously; data registers are not reset.
// Top level of the vectoring CORDIC arctangent core.
// Depends on cva_pkg for the arctangent table and the pi constants.
`default_nettype none

module cordic_vectoring_atan2_core
  import cva_pkg::*;
#(
  parameter int unsigned LAST_STEP       = LAST_STEP_DEFAULT,
  parameter int unsigned COORD_WIDTH     = COORD_WIDTH_DEFAULT,
  parameter int unsigned ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [COORD_WIDTH-1:0] y_value_i,
  input  wire logic signed [COORD_WIDTH-1:0] x_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [ANGLE_WIDTH-1:0]      angle_o
);

  localparam int unsigned W = COORD_WIDTH + 2;
  localparam int unsigned N = LAST_STEP + 1;
  localparam angle_t PI      = pi_value(ANGLE_FRAC_BITS, 0);
  localparam angle_t HALF_PI = pi_value(ANGLE_FRAC_BITS, 1);

  logic advance;

  logic                vld_q   [0:N];
  logic signed [W-1:0] x_q     [0:N-1];
  logic signed [W-1:0] y_q     [0:N-1];
  angle_t              z_q     [0:N];
  logic                spec_q  [0:N];
  angle_t              sres_q  [0:N];
  logic                xneg_q  [0:N];
  logic                yneg_q  [0:N];

  logic   out_vld_q;
  angle_t angle_q;

  // The whole pipeline moves unless a finished result is held at the output.
  assign advance    = !(out_vld_q && out_stall_i);
  assign in_stall_o = !advance;

  // Entry stage: special cases and absolute values.
  logic signed [W-1:0] x_ext, y_ext;
  logic                spec_d;
  angle_t              sres_d;

  assign x_ext = W'(x_value_i);
  assign y_ext = W'(y_value_i);

  always_comb begin
    spec_d = 1'b0;
    sres_d = '0;
    if (y_value_i == '0) begin
      spec_d = 1'b1;
      sres_d = x_value_i[COORD_WIDTH-1] ? PI : angle_t'(0);
    end else if (x_value_i == '0) begin
      spec_d = 1'b1;
      sres_d = y_value_i[COORD_WIDTH-1] ? (angle_t'(0) - HALF_PI) : HALF_PI;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (advance) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      x_q[0]    <= x_value_i[COORD_WIDTH-1] ? -x_ext : x_ext;
      y_q[0]    <= y_value_i[COORD_WIDTH-1] ? -y_ext : y_ext;
      z_q[0]    <= '0;
      spec_q[0] <= spec_d;
      sres_q[0] <= sres_d;
      xneg_q[0] <= x_value_i[COORD_WIDTH-1];
      yneg_q[0] <= y_value_i[COORD_WIDTH-1];
    end
  end

  // One iteration per stage; stage i+1 holds the state after iteration i.
  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam angle_t STEP_ANGLE = atan_entry(4'(i), ANGLE_FRAC_BITS);

    logic rot_neg;
    assign rot_neg = !y_q[i][W-1] && (y_q[i] != '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (advance) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        z_q[i+1]    <= rot_neg ? (z_q[i] + STEP_ANGLE) : (z_q[i] - STEP_ANGLE);
        spec_q[i+1] <= spec_q[i];
        sres_q[i+1] <= sres_q[i];
        xneg_q[i+1] <= xneg_q[i];
        yneg_q[i+1] <= yneg_q[i];
      end
    end

    // The last iteration only needs the angle; x and y are not carried further.
    if (i < N - 1) begin : g_xy
      logic signed [W-1:0] xs, ys;
      assign xs = x_q[i] >>> i;
      assign ys = y_q[i] >>> i;

      always_ff @(posedge clk_i) begin
        if (advance) begin
          x_q[i+1] <= rot_neg ? (x_q[i] + ys) : (x_q[i] - ys);
          y_q[i+1] <= rot_neg ? (y_q[i] - xs) : (y_q[i] + xs);
        end
      end
    end
  end

  // Fold the first-quadrant angle back into the quadrant of the input, or pass the special-case result.
  angle_t angle_d;

  always_comb begin
    if (spec_q[N]) begin
      angle_d = sres_q[N];
    end else if (!xneg_q[N] && !yneg_q[N]) begin
      angle_d = z_q[N];
    end else if (xneg_q[N] && !yneg_q[N]) begin
      angle_d = PI - z_q[N];
    end else if (xneg_q[N]) begin
      angle_d = z_q[N] - PI;
    end else begin
      angle_d = angle_t'(0) - z_q[N];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      angle_q <= angle_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign angle_o     = angle_q;

endmodule

`default_nettype wire
